@@ sv/cpu_operand_fetch_top_defines.svh @@
// Assertion macros shared by the operand fetch RTL.
`ifndef CPU_OPERAND_FETCH_TOP_DEFINES_SVH
`define CPU_OPERAND_FETCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define COF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define COF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cof_pkg.sv @@
package cof_pkg;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  // High page used by (C) operands and A8 destinations.
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // Input word kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Result word kinds.
  localparam logic RK_REQUEST = 1'b0;
  localparam logic RK_FINAL   = 1'b1;

  // Addressing modes.
  localparam logic [4:0] MODE_IMP    = 5'd0;
  localparam logic [4:0] MODE_R      = 5'd1;
  localparam logic [4:0] MODE_R_R    = 5'd2;
  localparam logic [4:0] MODE_R_D8   = 5'd3;
  localparam logic [4:0] MODE_R_D16  = 5'd4;
  localparam logic [4:0] MODE_D16    = 5'd5;
  localparam logic [4:0] MODE_MR_R   = 5'd6;
  localparam logic [4:0] MODE_R_MR   = 5'd7;
  localparam logic [4:0] MODE_R_HLI  = 5'd8;
  localparam logic [4:0] MODE_R_HLD  = 5'd9;
  localparam logic [4:0] MODE_HLI_R  = 5'd10;
  localparam logic [4:0] MODE_HLD_R  = 5'd11;
  localparam logic [4:0] MODE_R_A8   = 5'd12;
  localparam logic [4:0] MODE_A8_R   = 5'd13;
  localparam logic [4:0] MODE_HL_SPR = 5'd14;
  localparam logic [4:0] MODE_D8     = 5'd15;
  localparam logic [4:0] MODE_A16_R  = 5'd16;
  localparam logic [4:0] MODE_D16_R  = 5'd17;
  localparam logic [4:0] MODE_MR_D8  = 5'd18;
  localparam logic [4:0] MODE_MR     = 5'd19;
  localparam logic [4:0] MODE_R_A16  = 5'd20;

  // Count of bus reads taken so far in a multi-byte fetch.
  localparam logic [1:0] READS_NONE = 2'd0;
  localparam logic [1:0] READS_ONE  = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [4:0]  mode;
    logic [15:0] reg1_value;
    logic [15:0] reg2_value;
    logic        reg1_is_c;
    logic        reg2_is_c;
    logic [15:0] program_counter;
    logic [15:0] hl_value;
    logic [7:0]  bus_data;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] read_address;
    logic [15:0] operand_value;
    logic [15:0] dest_addr;
    logic        dest_in_mem;
    logic [15:0] new_pc;
    logic [15:0] new_hl;
    logic        hl_written;
    logic        bad_mode;
  } result_t;

  // Step handshake from the core to the input and output stages.
  typedef struct packed {
    logic take;
    logic emit;
  } step_ctl_t;

endpackage

@@ sv/cof_in_stage.sv @@
`include "cpu_operand_fetch_top_defines.svh"

module cof_in_stage
  import cof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  step_ctl_t             ctl,
  output logic                  in_valid,
  output item_t                 item_q
);

  logic load;

  // A word can enter when the register is empty or drains this cycle.
  assign s_tready = !in_valid || ctl.take;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (load) begin
      in_valid <= 1'b1;
    end else if (ctl.take) begin
      in_valid <= 1'b0;
    end
  end

  // Unpack the word into its fields.
  always_ff @(posedge clk) begin
    if (load) begin
      item_q.kind            <= s_tuser;
      item_q.mode            <= s_tdata[4:0];
      item_q.reg1_value      <= s_tdata[20:5];
      item_q.reg2_value      <= s_tdata[36:21];
      item_q.reg1_is_c       <= s_tdata[37];
      item_q.reg2_is_c       <= s_tdata[38];
      item_q.program_counter <= s_tdata[54:39];
      item_q.hl_value        <= s_tdata[70:55];
      item_q.bus_data        <= s_tdata[78:71];
    end
  end

  `COF_ASSERT_NEXT(in_hold, clk, rst, in_valid && !ctl.take, in_valid && $stable(item_q), "held input word changed")
  `COF_ASSERT_NOW(take_needs_word, clk, rst, ctl.take, in_valid, "step taken with no input word")

endmodule

@@ sv/cof_core.sv @@
module cof_core
  import cof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  item_t     item_q,
  input  logic      out_free,
  output step_ctl_t ctl,
  output result_t   res
);

  // Fetch state.
  logic        busy, busy_next;
  logic [4:0]  held_mode, held_mode_next;
  logic [1:0]  reads_done, reads_done_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] working_pc, working_pc_next;
  logic [15:0] pending_dest, pending_dest_next;
  logic [15:0] pending_data, pending_data_next;
  logic [15:0] pending_hl, pending_hl_next;
  logic        pending_hl_write, pending_hl_write_next;
  logic [15:0] last_fetched, last_fetched_next;

  // Decisions of this step.
  logic        go;
  logic        do_req;
  logic        do_final;
  logic [15:0] req_addr;
  logic [15:0] fin_data;
  logic [15:0] fin_dest;
  logic        fin_mem;
  logic        fin_hlw;
  logic [15:0] fin_hl;
  logic        fin_bad;
  logic [15:0] r1_paged;
  logic [15:0] r2_paged;
  logic [15:0] word;
  logic [15:0] byte_ext;

  assign go       = in_valid && out_free;
  assign r1_paged = item_q.reg1_is_c ? (item_q.reg1_value | HIGH_PAGE) : item_q.reg1_value;
  assign r2_paged = item_q.reg2_is_c ? (item_q.reg2_value | HIGH_PAGE) : item_q.reg2_value;
  assign word     = {item_q.bus_data, low_byte};
  assign byte_ext = {8'h00, item_q.bus_data};

  // Next state and result for the word in the input register.
  always_comb begin
    busy_next             = busy;
    held_mode_next        = held_mode;
    reads_done_next       = reads_done;
    low_byte_next         = low_byte;
    working_pc_next       = working_pc;
    pending_dest_next     = pending_dest;
    pending_data_next     = pending_data;
    pending_hl_next       = pending_hl;
    pending_hl_write_next = pending_hl_write;
    last_fetched_next     = last_fetched;
    do_req   = 1'b0;
    do_final = 1'b0;
    req_addr = '0;
    fin_data = '0;
    fin_dest = '0;
    fin_mem  = 1'b0;
    fin_hlw  = 1'b0;
    fin_hl   = '0;
    fin_bad  = 1'b0;

    if (item_q.kind == KIND_START) begin
      held_mode_next        = item_q.mode;
      reads_done_next       = READS_NONE;
      working_pc_next       = item_q.program_counter;
      pending_hl_write_next = 1'b0;
      pending_dest_next     = item_q.reg1_value;
      pending_data_next     = item_q.reg2_value;
      case (item_q.mode)
        MODE_IMP: begin
          do_final = 1'b1;
          fin_data = last_fetched;
        end
        MODE_R: begin
          do_final = 1'b1;
          fin_data = item_q.reg1_value;
        end
        MODE_R_R: begin
          do_final = 1'b1;
          fin_data = item_q.reg2_value;
        end
        MODE_MR_R: begin
          do_final = 1'b1;
          fin_data = item_q.reg2_value;
          fin_dest = r1_paged;
          fin_mem  = 1'b1;
        end
        MODE_HLI_R, MODE_HLD_R: begin
          do_final = 1'b1;
          fin_data = item_q.reg2_value;
          fin_dest = item_q.reg1_value;
          fin_mem  = 1'b1;
          fin_hlw  = 1'b1;
          fin_hl   = (item_q.mode == MODE_HLI_R) ? item_q.hl_value + 16'd1
                                                 : item_q.hl_value - 16'd1;
        end
        MODE_R_D8, MODE_R_D16, MODE_D16, MODE_R_A8, MODE_A8_R, MODE_HL_SPR,
        MODE_D8, MODE_A16_R, MODE_D16_R, MODE_MR_D8, MODE_R_A16: begin
          do_req          = 1'b1;
          req_addr        = item_q.program_counter;
          working_pc_next = item_q.program_counter + 16'd1;
        end
        MODE_R_MR: begin
          do_req   = 1'b1;
          req_addr = r2_paged;
        end
        MODE_R_HLI, MODE_R_HLD: begin
          do_req                = 1'b1;
          req_addr              = item_q.reg2_value;
          pending_hl_write_next = 1'b1;
          pending_hl_next       = (item_q.mode == MODE_R_HLI) ? item_q.hl_value + 16'd1
                                                              : item_q.hl_value - 16'd1;
        end
        MODE_MR: begin
          do_req   = 1'b1;
          req_addr = item_q.reg1_value;
        end
        default: begin
          do_final = 1'b1;
          fin_data = last_fetched;
          fin_bad  = 1'b1;
        end
      endcase
    end else if (busy) begin
      reads_done_next = reads_done + 2'd1;
      case (held_mode)
        MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8: begin
          do_final = 1'b1;
          fin_data = byte_ext;
        end
        MODE_A8_R: begin
          do_final = 1'b1;
          fin_data = last_fetched;
          fin_dest = byte_ext | HIGH_PAGE;
          fin_mem  = 1'b1;
        end
        MODE_MR_D8, MODE_MR: begin
          do_final = 1'b1;
          fin_data = byte_ext;
          fin_dest = pending_dest;
          fin_mem  = 1'b1;
        end
        MODE_R_MR, MODE_R_HLI, MODE_R_HLD: begin
          do_final = 1'b1;
          fin_data = byte_ext;
          fin_hlw  = pending_hl_write;
          fin_hl   = pending_hl;
        end
        MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
          if (reads_done == READS_NONE) begin
            // Low byte in hand; fetch the high byte next.
            low_byte_next   = item_q.bus_data;
            do_req          = 1'b1;
            req_addr        = working_pc;
            working_pc_next = working_pc + 16'd1;
          end else if (held_mode == MODE_R_D16 || held_mode == MODE_D16) begin
            do_final = 1'b1;
            fin_data = word;
          end else if (held_mode == MODE_A16_R || held_mode == MODE_D16_R) begin
            do_final = 1'b1;
            fin_data = pending_data;
            fin_dest = word;
            fin_mem  = 1'b1;
          end else if (reads_done == READS_ONE) begin
            // Absolute address assembled; read the operand there.
            do_req   = 1'b1;
            req_addr = word;
          end else begin
            do_final = 1'b1;
            fin_data = byte_ext;
          end
        end
        default: begin
          do_final = 1'b1;
          fin_data = last_fetched;
        end
      endcase
    end

    // Common bookkeeping of a request or a final result.
    if (do_req) begin
      busy_next = 1'b1;
    end
    if (do_final) begin
      last_fetched_next     = fin_data;
      busy_next             = 1'b0;
      reads_done_next       = READS_NONE;
      pending_hl_write_next = 1'b0;
    end
  end

  // Result word.
  always_comb begin
    res.result_kind   = do_final ? RK_FINAL : RK_REQUEST;
    res.read_address  = do_req ? req_addr : 16'h0000;
    res.operand_value = do_final ? fin_data : 16'h0000;
    res.dest_addr     = (do_final && fin_mem) ? fin_dest : 16'h0000;
    res.dest_in_mem   = do_final && fin_mem;
    res.new_pc        = do_final ? working_pc_next : 16'h0000;
    res.new_hl        = (do_final && fin_hlw) ? fin_hl : 16'h0000;
    res.hl_written    = do_final && fin_hlw;
    res.bad_mode      = do_final && fin_bad;
  end

  assign ctl.take = go;
  assign ctl.emit = go && (do_req || do_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      held_mode        <= MODE_IMP;
      reads_done       <= READS_NONE;
      low_byte         <= '0;
      working_pc       <= '0;
      pending_dest     <= '0;
      pending_data     <= '0;
      pending_hl       <= '0;
      pending_hl_write <= 1'b0;
      last_fetched     <= '0;
    end else if (go) begin
      busy             <= busy_next;
      held_mode        <= held_mode_next;
      reads_done       <= reads_done_next;
      low_byte         <= low_byte_next;
      working_pc       <= working_pc_next;
      pending_dest     <= pending_dest_next;
      pending_data     <= pending_data_next;
      pending_hl       <= pending_hl_next;
      pending_hl_write <= pending_hl_write_next;
      last_fetched     <= last_fetched_next;
    end
  end

endmodule

@@ sv/cof_out_stage.sv @@
module cof_out_stage
  import cof_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  step_ctl_t ctl,
  input  result_t   res,
  input  logic      m_tready,
  output logic      m_tvalid,
  output logic      out_free,
  output result_t   res_q
);

  // The register can take a new result when empty or being read out.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res_q <= res;
    end
  end

endmodule

@@ sv/cpu_operand_fetch_top.sv @@
// Channel   Dir  tdata                                       tuser
// s_*       in   mode, reg1_value, reg2_value, reg1_is_c,    kind
//                reg2_is_c, program_counter, hl_value,
//                bus_data
// m_*       out  read_address, operand_value, dest_addr,     result_kind
//                dest_in_mem, new_pc, new_hl, hl_written,
//                bad_mode
//
// The accepting edge loads a word into the input register; its result enters the output
// register, raising m_tvalid, once that register is free. While m_tready is high, one
// word per cycle is sustained; a data word with no read outstanding gives no result.
// Reset (rst, synchronous) empties both registers and clears the fetch state.
// A stall on m_tready holds the output register; s_tready drops once the input
// register is also full.
`include "cpu_operand_fetch_top_defines.svh"

module cpu_operand_fetch_top
  import cof_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [4:0] mode, [20:5] reg1_value, [36:21] reg2_value, [37] reg1_is_c,
  // [38] reg2_is_c, [54:39] program_counter, [70:55] hl_value,
  // [78:71] bus_data, [79] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] kind
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [15:0] read_address, [31:16] operand_value, [47:32] dest_addr,
  // [48] dest_in_mem, [64:49] new_pc, [80:65] new_hl, [81] hl_written,
  // [82] bad_mode, [87:83] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [0] result_kind
  output logic                   m_tuser
);

  step_ctl_t ctl;
  item_t     item_q;
  result_t   res;
  result_t   res_q;
  logic      in_valid;
  logic      out_free;

  cof_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .ctl      (ctl),
    .in_valid (in_valid),
    .item_q   (item_q)
  );

  cof_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .item_q   (item_q),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  cof_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .out_free (out_free),
    .res_q    (res_q)
  );

  // Pack the result word.
  assign m_tuser = res_q.result_kind;
  assign m_tdata = {5'b00000, res_q.bad_mode, res_q.hl_written, res_q.new_hl,
                    res_q.new_pc, res_q.dest_in_mem, res_q.dest_addr,
                    res_q.operand_value, res_q.read_address};

  `COF_ASSERT_NOW(req_fields_clear, clk, rst,
    m_tvalid && res_q.result_kind == RK_REQUEST,
    res_q.operand_value == 16'h0000 && !res_q.dest_in_mem && !res_q.hl_written &&
    !res_q.bad_mode, "bus request carries final fields")
  `COF_ASSERT_NOW(bad_mode_plain, clk, rst, m_tvalid && res_q.bad_mode,
    res_q.result_kind == RK_FINAL && !res_q.dest_in_mem && !res_q.hl_written,
    "bad mode result has side effects")
  `COF_ASSERT_NOW(emit_when_free, clk, rst, ctl.emit, out_free,
    "result written over an unread word")

endmodule
